// ===== rtl/tit_pkg.sv =====
`default_nettype none
package tit_pkg;

  localparam int TimeW = 27;
  localparam int ValW  = 32;

  localparam logic [TimeW-1:0] StartReset = 27'd34200000;
  localparam logic [TimeW-1:0] EndReset   = 27'd57600000;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_STORED    = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_BACKWARDS = 3'd3,
    ST_FULL      = 3'd4,
    ST_NO_EARLY  = 3'd5,
    ST_NO_LATE   = 3'd6,
    ST_WINDOW    = 3'd7
  } status_t;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef enum logic {
    CFG_START = 1'b0,
    CFG_END   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic              op;
    logic [2:0]        symbol;
    logic [TimeW-1:0]  time_ms;
    logic signed [ValW-1:0] point_value;
  } in_item_t;

  typedef struct packed {
    logic signed [ValW-1:0] result_value;
    logic [2:0]             status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_SWAIT,
    S_SCHECK,
    S_RDLO,
    S_RDHI,
    S_SKIP,
    S_WAITHI,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [63:0]       dividend;
    logic [31:0]       divisor;
  } div_req_t;

endpackage
`default_nettype wire

// ===== rtl/tit_divider.sv =====
`default_nettype none
module tit_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tit_pkg::div_req_t  req,
  output logic                    done,
  output logic signed [63:0]      quotient
);
  logic        run;
  logic [6:0]  cnt;
  logic        neg;
  logic [63:0] q;
  logic [63:0] rem;
  logic [31:0] den;
  logic [64:0] trial;
  logic [63:0] shifted;

  assign shifted = {rem[62:0], q[63]};
  assign trial   = {1'b0, shifted} - {33'd0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.dividend[63];
      q   <= req.dividend[63] ? -req.dividend : req.dividend;
      rem <= '0;
      den <= req.divisor;
    end else if (run) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= shifted;
        q   <= {q[62:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? -$signed(q) : $signed(q);
endmodule
`default_nettype wire

// ===== rtl/timed_interpolation_table_top.sv =====
`default_nettype none
// Timed interpolation table. Each start transaction is one append or one query and gives
// exactly one result strobe; the receiver cannot stall. An append, and a query outside the
// session window, never raise busy: the result strobe is registered and rises in the cycle
// after the accepting cycle, so these can follow back to back. A query inside the window
// raises busy and steps through a binary search (SEARCH, SWAIT), SCHECK, the lower
// neighbor read (RDLO, RDHI), the upper neighbor read (WAITHI, with SKIP past a stored
// time equal to the query time), MUL and DIV; it ends early with its strobe when no
// earlier or no later point exists. The search does one synchronous point-memory read per
// step, followed by two neighbor reads, one 28x33 multiply and a radix-2 restoring
// division. Busy drops in the cycle of the result strobe.
module timed_interpolation_table_top #(
  parameter int SYMBOLS = 8,
  parameter int POINTS  = 512
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire tit_pkg::in_item_t   item,
  output logic                     result_strobe,
  output tit_pkg::out_item_t       result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [26:0]         cfg_data
);
  localparam int SymW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int PtW  = $clog2(POINTS);
  localparam int CntW = $clog2(POINTS + 1);
  localparam int AdrW = SymW + PtW;
  localparam int Depth = SYMBOLS * (2 ** PtW);

  logic [26:0] times_mem [Depth];
  logic [31:0] vals_mem  [Depth];
  logic [CntW-1:0] count_r [SYMBOLS];
  logic [26:0]     latest_r [SYMBOLS];

  logic [26:0] sess_start, sess_end;
  tit_pkg::state_t state, state_next;
  logic              strobe_next;

  logic [26:0]       qtime;
  logic [SymW-1:0]   sym;
  logic [CntW-1:0]   n;
  logic [CntW-1:0]   lo_b, hi_b, mid;
  logic [AdrW-1:0]   rd_addr;
  logic [26:0]       rd_time;
  logic [31:0]       rd_val;
  logic [26:0]       tlo, thi;
  logic signed [31:0] vlo, vhi;
  logic [CntW-1:0]   idx;
  logic signed [27:0] dt;
  logic signed [32:0] dv;
  logic signed [60:0] prod_w;
  logic signed [63:0] prod;
  logic               ddone;
  logic signed [63:0] dq;
  logic [SymW-1:0]    in_sym;
  logic               in_window;
  logic               store_ok;
  logic               hit_exact;
  logic               div_go;
  tit_pkg::div_req_t  dreq_w;

  function automatic logic [SymW-1:0] fold_sym(logic [2:0] s);
    logic [3:0] v;
    v = {1'b0, s};
    for (int k = 0; k < 8; k++) begin
      if (int'(v) >= SYMBOLS) v = v - 4'(SYMBOLS);
    end
    return SymW'(v);
  endfunction

  assign in_sym = fold_sym(item.symbol);
  assign cfg_ready = 1'b1;
  assign busy = (state != tit_pkg::S_IDLE);
  assign in_window = !(item.time_ms < sess_start || item.time_ms > sess_end);
  assign store_ok = !(count_r[in_sym] != '0 && item.time_ms <= latest_r[in_sym])
                    && count_r[in_sym] < CntW'(POINTS);
  assign hit_exact = (idx < n) && (rd_time == qtime);

  always_ff @(posedge clk) begin
    if (rst) begin
      sess_start <= tit_pkg::StartReset;
      sess_end   <= tit_pkg::EndReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tit_pkg::CFG_START: sess_start <= cfg_data;
        tit_pkg::CFG_END:   sess_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_time <= times_mem[rd_addr];
    rd_val  <= vals_mem[rd_addr];
    if (start && !busy && item.op == tit_pkg::OP_APPEND && store_ok) begin
      times_mem[{in_sym, count_r[in_sym][PtW-1:0]}] <= item.time_ms;
      vals_mem[{in_sym, count_r[in_sym][PtW-1:0]}]  <= item.point_value;
    end
  end

  assign mid = CntW'(({1'b0, lo_b} + {1'b0, hi_b}) >> 1);

  always_comb begin
    rd_addr = {sym, mid[PtW-1:0]};
    unique case (state) inside
      tit_pkg::S_RDLO:                 rd_addr = {sym, PtW'(idx - CntW'(1))};
      tit_pkg::S_RDHI, tit_pkg::S_SKIP: rd_addr = {sym, idx[PtW-1:0]};
      default: ;
    endcase
  end

  always_comb begin
    state_next  = state;
    strobe_next = 1'b0;
    unique case (state)
      tit_pkg::S_IDLE: if (start) begin
        if (item.op == tit_pkg::OP_APPEND || !in_window) strobe_next = 1'b1;
        else                                              state_next  = tit_pkg::S_SEARCH;
      end
      tit_pkg::S_SEARCH: state_next = (lo_b < hi_b) ? tit_pkg::S_SWAIT : tit_pkg::S_SCHECK;
      tit_pkg::S_SWAIT:  state_next = tit_pkg::S_SEARCH;
      tit_pkg::S_SCHECK: state_next = tit_pkg::S_RDLO;
      tit_pkg::S_RDLO: if (idx == '0) begin
        strobe_next = 1'b1;
        state_next  = tit_pkg::S_IDLE;
      end else begin
        state_next  = tit_pkg::S_RDHI;
      end
      tit_pkg::S_RDHI:   state_next = tit_pkg::S_WAITHI;
      tit_pkg::S_SKIP:   state_next = tit_pkg::S_WAITHI;
      tit_pkg::S_WAITHI: if (hit_exact) begin
        state_next  = tit_pkg::S_SKIP;
      end else if (idx >= n) begin
        strobe_next = 1'b1;
        state_next  = tit_pkg::S_IDLE;
      end else begin
        state_next  = tit_pkg::S_MUL;
      end
      tit_pkg::S_MUL:    state_next = tit_pkg::S_DIV;
      tit_pkg::S_DIV: if (ddone) begin
        strobe_next = 1'b1;
        state_next  = tit_pkg::S_IDLE;
      end
      default:           state_next = tit_pkg::S_IDLE;
    endcase
  end

  assign dt     = {1'b0, qtime - tlo};
  assign dv     = {vhi[31], vhi} - {vlo[31], vlo};
  assign prod_w = dt * dv;

  // Search: lo_b/hi_b bound first index with time >= t; hold lo_b==hi_b at end.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tit_pkg::S_IDLE;
      result_strobe <= 1'b0;
      for (int s = 0; s < SYMBOLS; s++) begin
        count_r[s]  <= '0;
        latest_r[s] <= '0;
      end
    end else begin
      state         <= state_next;
      result_strobe <= strobe_next;
      unique case (state)
        tit_pkg::S_IDLE: if (start) begin
          qtime <= item.time_ms;
          sym   <= in_sym;
          n     <= count_r[in_sym];
          lo_b  <= '0;
          hi_b  <= count_r[in_sym];
          result.result_value <= '0;
          if (item.op == tit_pkg::OP_APPEND) begin
            if (count_r[in_sym] != '0 && item.time_ms == latest_r[in_sym])
              result.status <= tit_pkg::ST_DUPLICATE;
            else if (count_r[in_sym] != '0 && item.time_ms < latest_r[in_sym])
              result.status <= tit_pkg::ST_BACKWARDS;
            else if (count_r[in_sym] >= CntW'(POINTS))
              result.status <= tit_pkg::ST_FULL;
            else begin
              result.status     <= tit_pkg::ST_STORED;
              count_r[in_sym]   <= count_r[in_sym] + CntW'(1);
              latest_r[in_sym]  <= item.time_ms;
            end
          end else if (!in_window) begin
            result.status <= tit_pkg::ST_WINDOW;
          end
        end
        tit_pkg::S_SWAIT:
          if (rd_time < qtime) lo_b <= mid + CntW'(1);
          else                 hi_b <= mid;
        tit_pkg::S_SCHECK: idx <= lo_b;
        tit_pkg::S_RDLO: if (idx == '0) result.status <= tit_pkg::ST_NO_EARLY;
        tit_pkg::S_RDHI: begin
          tlo <= rd_time;
          vlo <= rd_val;
        end
        tit_pkg::S_WAITHI: begin
          if (hit_exact) begin
            idx <= idx + CntW'(1);
          end else if (idx >= n) begin
            result.status <= tit_pkg::ST_NO_LATE;
          end else begin
            thi <= rd_time;
            vhi <= rd_val;
          end
        end
        tit_pkg::S_MUL: prod <= {{3{prod_w[60]}}, prod_w};
        tit_pkg::S_DIV: if (ddone) begin
          result.status       <= tit_pkg::ST_OK;
          result.result_value <= vlo + 32'(dq);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) div_go <= 1'b0;
    else     div_go <= (state == tit_pkg::S_MUL);
  end

  assign dreq_w.start    = div_go;
  assign dreq_w.dividend = prod;
  assign dreq_w.divisor  = {5'd0, thi - tlo};

  tit_divider u_div (
    .clk(clk), .rst(rst), .req(dreq_w), .done(ddone), .quotient(dq)
  );

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(start || busy)) else $error("result without transaction");
  a_idle_after: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> state == tit_pkg::S_IDLE) else $error("busy after result");
  a_start_res: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || result_strobe)) else $error("lost item");
`endif
endmodule
`default_nettype wire
